// ===== design/tib_pkg.sv =====
// shared constants, types and helpers for the bilinear table lookup
package tib_pkg;

  // table geometry and number format
  localparam int NX_MAX = 16;
  localparam int NY_MAX = 16;
  localparam int VW     = 32;
  localparam int FB     = 16;

  // derived widths
  localparam int XAW = $clog2(NX_MAX);
  localparam int YAW = $clog2(NY_MAX);
  localparam int GAW = $clog2(NX_MAX * NY_MAX);
  localparam int PW  = 5;
  localparam int CIW = 2;
  localparam int FW  = FB + 1;
  localparam int CW  = $clog2(FB);
  localparam int PRW = VW + FW + 2;

  // request operations
  localparam logic [1:0] OP_WRITE_X    = 2'd0;
  localparam logic [1:0] OP_WRITE_Y    = 2'd1;
  localparam logic [1:0] OP_WRITE_GRID = 2'd2;
  localparam logic [1:0] OP_QUERY      = 2'd3;

  // configuration register indexes
  localparam logic [CIW-1:0] CFG_X_POINTS = CIW'(0);
  localparam logic [CIW-1:0] CFG_Y_POINTS = CIW'(1);

  typedef struct packed {
    logic [1:0]           operation;
    logic [7:0]           write_index;
    logic signed [VW-1:0] write_value;
    logic signed [31:0]   query_x;
    logic signed [31:0]   query_y;
  } request_t;

  typedef struct packed {
    logic signed [VW-1:0] z_value;
    logic                 degenerate_cell;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_END1, ST_CLAMP, ST_PROBE, ST_STEP, ST_LIMIT,
    ST_CELL0, ST_CELL1, ST_CELLCAP, ST_FX_SETUP, ST_DIV_X, ST_FY_SETUP,
    ST_DIV_Y, ST_GRD0, ST_GRD1, ST_GRD2, ST_GRD3, ST_GCAP,
    ST_MUL0, ST_SUM0, ST_MUL1, ST_SUM1, ST_MUL2, ST_SUM2
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_WRITE, DP_END0, DP_END1, DP_CLAMP, DP_PROBE, DP_STEP,
    DP_LIMIT, DP_CELL0, DP_CELL1, DP_CELLCAP, DP_FX_SETUP, DP_FY_SETUP,
    DP_DIV, DP_GRD0, DP_GRD1, DP_GRD2, DP_GRD3, DP_GCAP,
    DP_MUL0, DP_SUM0, DP_MUL1, DP_SUM1, DP_MUL2, DP_SUM2
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic search_done;
    logic fx_skip;
    logic fy_skip;
    logic div_last;
  } dp_status_t;

  // register value limited to 2 .. maxn
  function automatic logic [PW-1:0] points_in_use(input logic [PW-1:0] r,
                                                  input int maxn);
    logic [PW-1:0] v;
    begin
      if (r < PW'(2)) begin
        v = PW'(2);
      end else if (int'(r) > maxn) begin
        v = PW'(maxn);
      end else begin
        v = r;
      end
      return v;
    end
  endfunction

endpackage

// ===== design/tib_ctrl.sv =====
// sequencing state machine for the bilinear table lookup
module tib_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tib_pkg::dp_status_t status,
  output tib_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  tib_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tib_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = tib_pkg::DP_NOP;
    case (state)
      tib_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op     = tib_pkg::DP_LOAD;
          state_next = tib_pkg::ST_DECODE;
        end
      end
      tib_pkg::ST_DECODE: begin
        if (status.is_query) begin
          cmd.op     = tib_pkg::DP_END0;
          state_next = tib_pkg::ST_END1;
        end else begin
          cmd.op     = tib_pkg::DP_WRITE;
          state_next = tib_pkg::ST_IDLE;
        end
      end
      tib_pkg::ST_END1: begin
        cmd.op     = tib_pkg::DP_END1;
        state_next = tib_pkg::ST_CLAMP;
      end
      tib_pkg::ST_CLAMP: begin
        cmd.op     = tib_pkg::DP_CLAMP;
        state_next = tib_pkg::ST_PROBE;
      end
      tib_pkg::ST_PROBE: begin
        if (status.search_done) begin
          state_next = tib_pkg::ST_LIMIT;
        end else begin
          cmd.op     = tib_pkg::DP_PROBE;
          state_next = tib_pkg::ST_STEP;
        end
      end
      tib_pkg::ST_STEP: begin
        cmd.op     = tib_pkg::DP_STEP;
        state_next = tib_pkg::ST_PROBE;
      end
      tib_pkg::ST_LIMIT: begin
        cmd.op     = tib_pkg::DP_LIMIT;
        state_next = tib_pkg::ST_CELL0;
      end
      tib_pkg::ST_CELL0: begin
        cmd.op     = tib_pkg::DP_CELL0;
        state_next = tib_pkg::ST_CELL1;
      end
      tib_pkg::ST_CELL1: begin
        cmd.op     = tib_pkg::DP_CELL1;
        state_next = tib_pkg::ST_CELLCAP;
      end
      tib_pkg::ST_CELLCAP: begin
        cmd.op     = tib_pkg::DP_CELLCAP;
        state_next = tib_pkg::ST_FX_SETUP;
      end
      tib_pkg::ST_FX_SETUP: begin
        cmd.op     = tib_pkg::DP_FX_SETUP;
        state_next = status.fx_skip ? tib_pkg::ST_FY_SETUP : tib_pkg::ST_DIV_X;
      end
      tib_pkg::ST_DIV_X: begin
        cmd.op = tib_pkg::DP_DIV;
        if (status.div_last) begin
          state_next = tib_pkg::ST_FY_SETUP;
        end
      end
      tib_pkg::ST_FY_SETUP: begin
        cmd.op     = tib_pkg::DP_FY_SETUP;
        state_next = status.fy_skip ? tib_pkg::ST_GRD0 : tib_pkg::ST_DIV_Y;
      end
      tib_pkg::ST_DIV_Y: begin
        cmd.op = tib_pkg::DP_DIV;
        if (status.div_last) begin
          state_next = tib_pkg::ST_GRD0;
        end
      end
      tib_pkg::ST_GRD0: begin
        cmd.op     = tib_pkg::DP_GRD0;
        state_next = tib_pkg::ST_GRD1;
      end
      tib_pkg::ST_GRD1: begin
        cmd.op     = tib_pkg::DP_GRD1;
        state_next = tib_pkg::ST_GRD2;
      end
      tib_pkg::ST_GRD2: begin
        cmd.op     = tib_pkg::DP_GRD2;
        state_next = tib_pkg::ST_GRD3;
      end
      tib_pkg::ST_GRD3: begin
        cmd.op     = tib_pkg::DP_GRD3;
        state_next = tib_pkg::ST_GCAP;
      end
      tib_pkg::ST_GCAP: begin
        cmd.op     = tib_pkg::DP_GCAP;
        state_next = tib_pkg::ST_MUL0;
      end
      tib_pkg::ST_MUL0: begin
        cmd.op     = tib_pkg::DP_MUL0;
        state_next = tib_pkg::ST_SUM0;
      end
      tib_pkg::ST_SUM0: begin
        cmd.op     = tib_pkg::DP_SUM0;
        state_next = tib_pkg::ST_MUL1;
      end
      tib_pkg::ST_MUL1: begin
        cmd.op     = tib_pkg::DP_MUL1;
        state_next = tib_pkg::ST_SUM1;
      end
      tib_pkg::ST_SUM1: begin
        cmd.op     = tib_pkg::DP_SUM1;
        state_next = tib_pkg::ST_MUL2;
      end
      tib_pkg::ST_MUL2: begin
        cmd.op     = tib_pkg::DP_MUL2;
        state_next = tib_pkg::ST_SUM2;
      end
      tib_pkg::ST_SUM2: begin
        cmd.op     = tib_pkg::DP_SUM2;
        state_next = tib_pkg::ST_IDLE;
      end
      default: begin
        state_next = tib_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != tib_pkg::ST_IDLE);

endmodule

// ===== design/tib_dp.sv =====
// datapath: axis and grid memories, search, fraction divider, interpolation
module tib_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  tib_pkg::request_t           request,
  input  logic                        cfg_we,
  input  logic [tib_pkg::CIW-1:0]     cfg_index,
  input  logic [tib_pkg::PW-1:0]      cfg_data,
  input  tib_pkg::dp_cmd_t            cmd,
  output tib_pkg::dp_status_t         status,
  output tib_pkg::result_t            result,
  output logic                        done
);

  localparam int VW  = tib_pkg::VW;
  localparam int FB  = tib_pkg::FB;
  localparam int FW  = tib_pkg::FW;
  localparam int XAW = tib_pkg::XAW;
  localparam int YAW = tib_pkg::YAW;
  localparam int GAW = tib_pkg::GAW;
  localparam int PW  = tib_pkg::PW;
  localparam int CW  = tib_pkg::CW;
  localparam int PRW = tib_pkg::PRW;

  tib_pkg::request_t rq;
  logic [PW-1:0]     x_points, y_points;
  logic [PW-1:0]     nx, ny;

  logic signed [VW-1:0] x_mem [tib_pkg::NX_MAX];
  logic signed [VW-1:0] y_mem [tib_pkg::NY_MAX];
  logic signed [VW-1:0] g_mem [tib_pkg::NX_MAX * tib_pkg::NY_MAX];
  logic [XAW-1:0]       x_addr;
  logic [YAW-1:0]       y_addr;
  logic [GAW-1:0]       g_addr;
  logic signed [VW-1:0] x_rd, y_rd, g_rd;

  logic signed [VW-1:0] x_end0, y_end0, xc, yc;
  logic [XAW-1:0]       xlo, xhi, x_mid;
  logic [YAW-1:0]       ylo, yhi, y_mid;
  logic signed [VW-1:0] x_cl, x_ch, y_cl, y_ch;
  logic [FW-1:0]        tx, ty;
  logic                 deg;

  logic signed [VW:0]   wx, dx, wy, dy;
  logic [VW:0]          dxc, dyc;
  logic                 x_wz, x_sat, y_wz, y_sat;

  logic                 div_sel;
  logic [VW:0]          div_w;
  logic [VW+1:0]        div_r, div_r2, div_rn;
  logic [FB-1:0]        div_q, div_qn;
  logic [CW-1:0]        div_cnt;
  logic                 div_ge;

  logic [GAW:0]         gb0, gb1;
  logic signed [VW-1:0] ga, gb, gc, gd, z0, z1;

  logic signed [VW-1:0] m_a, m_b, mul_a;
  logic [FW-1:0]        m_t;
  logic signed [VW:0]   m_diff;
  logic signed [PRW-1:0] prod, p_rnd, p_sh;
  logic signed [VW-1:0] lerp_sum;

  assign nx = tib_pkg::points_in_use(x_points, tib_pkg::NX_MAX);
  assign ny = tib_pkg::points_in_use(y_points, tib_pkg::NY_MAX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_points <= PW'(2);
      y_points <= PW'(2);
    end else if (cfg_we) begin
      if (cfg_index == tib_pkg::CFG_X_POINTS) begin
        x_points <= cfg_data;
      end
      if (cfg_index == tib_pkg::CFG_Y_POINTS) begin
        y_points <= cfg_data;
      end
    end
  end

  // binary search midpoints
  assign x_mid = XAW'(({1'b0, xlo} + {1'b0, xhi} + (XAW+1)'(1)) >> 1);
  assign y_mid = YAW'(({1'b0, ylo} + {1'b0, yhi} + (YAW+1)'(1)) >> 1);

  // grid corner addresses, row index on x
  assign gb0 = (GAW+1)'(xhi) * (GAW+1)'(ny) + (GAW+1)'(yhi);
  assign gb1 = gb0 + (GAW+1)'(ny);

  // read address selection
  always_comb begin
    x_addr = rq.write_index[XAW-1:0];
    y_addr = rq.write_index[YAW-1:0];
    g_addr = rq.write_index[GAW-1:0];
    case (cmd.op)
      tib_pkg::DP_END0: begin
        x_addr = '0;
        y_addr = '0;
      end
      tib_pkg::DP_END1: begin
        x_addr = XAW'(nx - PW'(1));
        y_addr = YAW'(ny - PW'(1));
      end
      tib_pkg::DP_PROBE: begin
        x_addr = x_mid;
        y_addr = y_mid;
      end
      tib_pkg::DP_CELL0: begin
        x_addr = xhi;
        y_addr = yhi;
      end
      tib_pkg::DP_CELL1: begin
        x_addr = xhi + XAW'(1);
        y_addr = yhi + YAW'(1);
      end
      tib_pkg::DP_GRD0: g_addr = GAW'(gb0);
      tib_pkg::DP_GRD1: g_addr = GAW'(gb1);
      tib_pkg::DP_GRD2: g_addr = GAW'(gb0 + (GAW+1)'(1));
      tib_pkg::DP_GRD3: g_addr = GAW'(gb1 + (GAW+1)'(1));
      default: ;
    endcase
  end

  // memories: write on a write request, registered read every cycle
  always_ff @(posedge clk) begin
    if (cmd.op == tib_pkg::DP_WRITE) begin
      if (rq.operation == tib_pkg::OP_WRITE_X &&
          int'(rq.write_index) < tib_pkg::NX_MAX) begin
        x_mem[rq.write_index[XAW-1:0]] <= rq.write_value;
      end
      if (rq.operation == tib_pkg::OP_WRITE_Y &&
          int'(rq.write_index) < tib_pkg::NY_MAX) begin
        y_mem[rq.write_index[YAW-1:0]] <= rq.write_value;
      end
      if (rq.operation == tib_pkg::OP_WRITE_GRID &&
          int'(rq.write_index) < tib_pkg::NX_MAX * tib_pkg::NY_MAX) begin
        g_mem[rq.write_index[GAW-1:0]] <= rq.write_value;
      end
    end
    x_rd <= x_mem[x_addr];
    y_rd <= y_mem[y_addr];
    g_rd <= g_mem[g_addr];
  end

  // cell width and offset for both fractions
  always_comb begin
    wx    = {x_ch[VW-1], x_ch} - {x_cl[VW-1], x_cl};
    dx    = {xc[VW-1], xc} - {x_cl[VW-1], x_cl};
    wy    = {y_ch[VW-1], y_ch} - {y_cl[VW-1], y_cl};
    dy    = {yc[VW-1], yc} - {y_cl[VW-1], y_cl};
    dxc   = dx[VW] ? '0 : dx;
    dyc   = dy[VW] ? '0 : dy;
    x_wz  = wx[VW] || (wx == '0);
    y_wz  = wy[VW] || (wy == '0);
    x_sat = !x_wz && (dxc >= (VW+1)'(wx));
    y_sat = !y_wz && (dyc >= (VW+1)'(wy));
  end

  // one restoring division step
  always_comb begin
    div_r2 = {div_r[VW:0], 1'b0};
    div_ge = (div_r2 >= {1'b0, div_w});
    div_rn = div_ge ? (div_r2 - {1'b0, div_w}) : div_r2;
    div_qn = {div_q[FB-2:0], div_ge};
  end

  // interpolation operand selection, rounding and add
  always_comb begin
    m_a = z0;
    m_b = z1;
    m_t = ty;
    case (cmd.op)
      tib_pkg::DP_MUL0: begin
        m_a = ga;
        m_b = gb;
        m_t = tx;
      end
      tib_pkg::DP_MUL1: begin
        m_a = gc;
        m_b = gd;
        m_t = tx;
      end
      default: ;
    endcase
    m_diff   = {m_b[VW-1], m_b} - {m_a[VW-1], m_a};
    p_rnd    = prod + PRW'(1 << (FB - 1));
    p_sh     = p_rnd >>> FB;
    lerp_sum = mul_a + p_sh[VW-1:0];
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      tib_pkg::DP_LOAD: begin
        rq  <= request;
        deg <= 1'b0;
      end
      tib_pkg::DP_END1: begin
        x_end0 <= x_rd;
        y_end0 <= y_rd;
      end
      tib_pkg::DP_CLAMP: begin
        if (rq.query_x <= x_end0) begin
          xc <= x_end0;
        end else if (rq.query_x >= x_rd) begin
          xc <= x_rd;
        end else begin
          xc <= rq.query_x;
        end
        if (rq.query_y <= y_end0) begin
          yc <= y_end0;
        end else if (rq.query_y >= y_rd) begin
          yc <= y_rd;
        end else begin
          yc <= rq.query_y;
        end
        xlo <= '0;
        ylo <= '0;
        xhi <= XAW'(nx - PW'(1));
        yhi <= YAW'(ny - PW'(1));
      end
      tib_pkg::DP_STEP: begin
        if (xlo < xhi) begin
          if (x_rd <= xc) begin
            xlo <= x_mid;
          end else begin
            xhi <= x_mid - XAW'(1);
          end
        end
        if (ylo < yhi) begin
          if (y_rd <= yc) begin
            ylo <= y_mid;
          end else begin
            yhi <= y_mid - YAW'(1);
          end
        end
      end
      tib_pkg::DP_LIMIT: begin
        if (PW'(xhi) > nx - PW'(2)) begin
          xhi <= XAW'(nx - PW'(2));
        end
        if (PW'(yhi) > ny - PW'(2)) begin
          yhi <= YAW'(ny - PW'(2));
        end
      end
      tib_pkg::DP_CELL1: begin
        x_cl <= x_rd;
        y_cl <= y_rd;
      end
      tib_pkg::DP_CELLCAP: begin
        x_ch <= x_rd;
        y_ch <= y_rd;
      end
      tib_pkg::DP_FX_SETUP: begin
        div_sel <= 1'b0;
        div_w   <= wx;
        div_r   <= {1'b0, dxc};
        div_q   <= '0;
        div_cnt <= '0;
        if (x_wz) begin
          tx  <= '0;
          deg <= 1'b1;
        end else if (x_sat) begin
          tx <= FW'(1) << FB;
        end
      end
      tib_pkg::DP_FY_SETUP: begin
        div_sel <= 1'b1;
        div_w   <= wy;
        div_r   <= {1'b0, dyc};
        div_q   <= '0;
        div_cnt <= '0;
        if (y_wz) begin
          ty  <= '0;
          deg <= 1'b1;
        end else if (y_sat) begin
          ty <= FW'(1) << FB;
        end
      end
      tib_pkg::DP_DIV: begin
        div_r   <= div_rn;
        div_q   <= div_qn;
        div_cnt <= div_cnt + CW'(1);
        if (status.div_last) begin
          if (div_sel) begin
            ty <= {1'b0, div_qn};
          end else begin
            tx <= {1'b0, div_qn};
          end
        end
      end
      tib_pkg::DP_GRD1: ga <= g_rd;
      tib_pkg::DP_GRD2: gb <= g_rd;
      tib_pkg::DP_GRD3: gc <= g_rd;
      tib_pkg::DP_GCAP: gd <= g_rd;
      tib_pkg::DP_MUL0, tib_pkg::DP_MUL1, tib_pkg::DP_MUL2: begin
        mul_a <= m_a;
        prod  <= PRW'(m_diff * $signed({1'b0, m_t}));
      end
      tib_pkg::DP_SUM0: z0 <= lerp_sum;
      tib_pkg::DP_SUM1: z1 <= lerp_sum;
      tib_pkg::DP_SUM2: begin
        result.z_value         <= lerp_sum;
        result.degenerate_cell <= deg;
      end
      default: ;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == tib_pkg::DP_SUM2);
    end
  end

  // status towards the controller
  always_comb begin
    status.is_query    = (rq.operation == tib_pkg::OP_QUERY);
    status.search_done = !(xlo < xhi) && !(ylo < yhi);
    status.fx_skip     = x_wz || x_sat;
    status.fy_skip     = y_wz || y_sat;
    status.div_last    = (div_cnt == CW'(FB - 1));
  end

endmodule

// ===== design/table_interp_bilinear_2d.sv =====
// top level of the two-dimensional bilinear table lookup
//
// Request channel: a request is taken on a rising edge with start high and
// busy low. Operations write an x breakpoint, a y breakpoint or a grid entry
// (index row * y points in use + column, row on x), or run a query.
// A write request holds busy high through its decode state and gives no result.
// A query gives one result: done is high for exactly one cycle with z_value
// and degenerate_cell on result. done rises in the cycle busy falls.
// A query keeps busy high through two end reads, a binary search with a
// probe and a step state per probe (up to four probes for sixteen
// breakpoints), cell reads, two 16-step restoring divisions for the cell
// fractions (each skipped when the offset reaches the cell width or the
// cell has zero or negative width), four grid reads on the single grid
// port and three multiply and round steps on one shared multiplier.
// One request is handled at a time; the next may start once busy is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data set the
// x and y point counts; cfg_ready is always high. Write it only while idle.
// Reset (rst, synchronous) returns to idle, drops done and sets both point
// counts to two; table contents are kept and are undefined until written.
// The receiver cannot stall: a result must be taken in its done cycle.
module table_interp_bilinear_2d (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  tib_pkg::request_t       request,
  output logic                    done,
  output tib_pkg::result_t        result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [tib_pkg::CIW-1:0] cfg_index,
  input  logic [tib_pkg::PW-1:0]  cfg_data
);

  tib_pkg::dp_cmd_t    cmd;
  tib_pkg::dp_status_t status;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  // sequencer
  tib_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath
  tib_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule

// ===== design/tib_checker.sv =====
// port-level checks for the bilinear table lookup, bound to the top level
module tib_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input tib_pkg::request_t request,
  input logic              done
);

  // a result comes only as the work ends
  a_done_ends_work: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside end of work");

  // a write request raises busy, returns to idle and gives no result
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation != tib_pkg::OP_QUERY)
      |=> busy && !done ##1 !busy && !done)
    else $error("write request misbehaved");

  // a query keeps the block busy past the decode cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation == tib_pkg::OP_QUERY)
      |=> busy ##1 busy)
    else $error("query request not held busy");

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("not idle after reset");

endmodule

bind table_interp_bilinear_2d tib_checker u_tib_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done)
);

// ===== tb/table_interp_bilinear_2d_test.sv =====
// testbench for the two-dimensional bilinear table lookup
`timescale 1ns / 100ps

module table_interp_bilinear_2d_test;
  import tib_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 100;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  request_t            request;
  logic                done;
  result_t             result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIW-1:0]      cfg_index;
  logic [PW-1:0]       cfg_data;

  // shadow copy of the table contents and point counts
  longint              x_bp [NX_MAX];
  longint              y_bp [NY_MAX];
  longint              z_tab [NX_MAX * NY_MAX];
  logic [PW-1:0]       x_count;
  logic [PW-1:0]       y_count;

  result_t             z_expected [$];
  int                  idle_pct;
  int                  n_requests;
  int                  n_queries;
  int                  n_results;
  int                  n_errors;
  int                  n_cycles;

  table_interp_bilinear_2d dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("table_interp_bilinear_2d_test: done, errors");
      $finish;
    end
  end

  // point count limited to 2 .. maxn
  function automatic int pts(input logic [PW-1:0] r, input int maxn);
    if (r < 2) return 2;
    if (int'(r) > maxn) return maxn;
    return int'(r);
  endfunction

  // last breakpoint not above t, limited to the last cell
  function automatic int find_cell(input longint ax [16], input int n, input longint t);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (ax[mid] <= t) lo = mid;
      else hi = mid - 1;
    end
    if (hi > n - 2) hi = n - 2;
    return hi;
  endfunction

  // cell fraction by restoring division, flags a cell of zero or negative width
  function automatic longint cell_frac(input longint v, input longint lo, input longint hi,
                                       inout bit deg);
    longint w;
    longint d;
    longint r;
    longint q;
    w = hi - lo;
    d = v - lo;
    q = 0;
    if (w <= 0) begin
      deg = 1'b1;
      return 0;
    end
    if (d < 0) d = 0;
    if (d >= w) return longint'(1) << FB;
    r = d;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= w) begin
        r = r - w;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // one interpolation step with rounding, floor on the scaled product
  function automatic longint blend(input longint a, input longint b, input longint t);
    longint p;
    p = (b - a) * t + (longint'(1) << (FB - 1));
    return a + (p >>> FB);
  endfunction

  // expected result of one query
  function automatic result_t lookup_expect(input longint qx, input longint qy);
    int      nx;
    int      ny;
    int      ix;
    int      iy;
    int      b0;
    int      b1;
    longint  xc;
    longint  yc;
    longint  tx;
    longint  ty;
    longint  z0;
    longint  z1;
    longint  z;
    bit      deg;
    result_t res;
    nx = pts(x_count, NX_MAX);
    ny = pts(y_count, NY_MAX);
    deg = 1'b0;
    xc = qx;
    if (qx <= x_bp[0]) xc = x_bp[0];
    else if (qx >= x_bp[nx-1]) xc = x_bp[nx-1];
    yc = qy;
    if (qy <= y_bp[0]) yc = y_bp[0];
    else if (qy >= y_bp[ny-1]) yc = y_bp[ny-1];
    ix = find_cell(x_bp, nx, xc);
    iy = find_cell(y_bp, ny, yc);
    tx = cell_frac(xc, x_bp[ix], x_bp[ix+1], deg);
    ty = cell_frac(yc, y_bp[iy], y_bp[iy+1], deg);
    b0 = ix * ny + iy;
    b1 = (ix + 1) * ny + iy;
    z0 = blend(z_tab[b0], z_tab[b1], tx);
    z1 = blend(z_tab[b0+1], z_tab[b1+1], tx);
    z = blend(z0, z1, ty);
    res.z_value = z[VW-1:0];
    res.degenerate_cell = deg;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      n_results++;
      if (z_expected.size() == 0) begin
        $error("result with nothing expected: z_value %0d", $signed(result.z_value));
        n_errors++;
      end else begin
        e = z_expected.pop_front();
        if (result.z_value !== e.z_value) begin
          $error("z_value: expected %0d, actual %0d", $signed(e.z_value),
                 $signed(result.z_value));
          n_errors++;
        end
        if (result.degenerate_cell !== e.degenerate_cell) begin
          $error("degenerate_cell: expected %0b, actual %0b", e.degenerate_cell,
                 result.degenerate_cell);
          n_errors++;
        end
      end
    end
  end

  // send one request and update the shadow state once it is taken
  task automatic send(input request_t r);
    int gap;
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    n_requests++;
    case (r.operation)
      OP_WRITE_X:    if (r.write_index < NX_MAX) x_bp[r.write_index] = longint'(r.write_value);
      OP_WRITE_Y:    if (r.write_index < NY_MAX) y_bp[r.write_index] = longint'(r.write_value);
      OP_WRITE_GRID: z_tab[r.write_index] = longint'(r.write_value);
      default: begin
        n_queries++;
        z_expected.push_back(lookup_expect(longint'(r.query_x), longint'(r.query_y)));
      end
    endcase
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write(input logic [1:0] op, input int idx, input logic [31:0] val);
    request_t r;
    r = '0;
    r.operation = op;
    r.write_index = idx[7:0];
    r.write_value = val;
    r.query_x = $urandom;
    r.query_y = $urandom;
    send(r);
  endtask

  task automatic send_query(input logic [31:0] qx, input logic [31:0] qy);
    request_t r;
    r.operation = OP_QUERY;
    r.write_index = $urandom;
    r.write_value = $urandom;
    r.query_x = qx;
    r.query_y = qy;
    send(r);
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (z_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // point count write, only while idle
  task automatic set_points(input logic [CIW-1:0] idx, input logic [PW-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_X_POINTS) x_count = val;
    else y_count = val;
    @(posedge clk);
  endtask

  // ascending breakpoints, some cells of zero width
  task automatic load_axis(input logic [1:0] op, input int spread);
    longint v;
    v = longint'($signed($urandom_range(0, 2 * spread))) - spread;
    for (int i = 0; i < 16; i++) begin
      send_write(op, i, v[31:0]);
      if ($urandom_range(99) >= 5) v = v + $urandom_range(1, spread / 8 + 1);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
  endtask

  // coordinate near the span of an axis, sometimes anywhere
  function automatic logic [31:0] pick_coord(input longint a, input longint b);
    longint lo;
    longint hi;
    longint m;
    longint v;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if ($urandom_range(99) < 10) return $urandom;
    m = (hi - lo) / 8 + 4;
    v = lo - m + longint'({$urandom, $urandom} % ((hi - lo + 2 * m + 1)));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic random_query();
    int nx;
    int ny;
    int k;
    logic [31:0] qx;
    logic [31:0] qy;
    nx = pts(x_count, NX_MAX);
    ny = pts(y_count, NY_MAX);
    k = $urandom_range(0, nx - 1);
    if ($urandom_range(99) < 15) qx = x_bp[k][31:0];
    else qx = pick_coord(x_bp[0], x_bp[nx-1]);
    k = $urandom_range(0, ny - 1);
    if ($urandom_range(99) < 15) qy = y_bp[k][31:0];
    else qy = pick_coord(y_bp[0], y_bp[ny-1]);
    send_query(qx, qy);
  endtask

  // fill every table entry so no query reads an unwritten one
  task automatic test_table_load();
    load_axis(OP_WRITE_X, 1 << 20);
    load_axis(OP_WRITE_Y, 1 << 20);
    for (int i = 0; i < NX_MAX * NY_MAX; i++)
      send_write(OP_WRITE_GRID, i, $urandom_range(0, 1 << 24) - (1 << 23));
  endtask

  // field extremes, clamping, zero-width and non-ascending cells
  task automatic test_directed();
    set_points(CFG_X_POINTS, 5'd4);
    set_points(CFG_Y_POINTS, 5'd3);
    send_write(OP_WRITE_GRID, 0, 32'h8000_0000);
    send_write(OP_WRITE_GRID, 3, 32'h7FFF_FFFF);
    send_write(OP_WRITE_GRID, 255, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(x_bp[1][31:0], y_bp[1][31:0]);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    // writes beyond the axis depth are dropped
    send_write(OP_WRITE_X, 16, 32'hFFFF_FFFF);
    send_write(OP_WRITE_Y, 255, 32'h0);
    // zero-width cell along x
    send_write(OP_WRITE_X, 1, x_bp[0][31:0]);
    send_query(x_bp[0][31:0], 32'h0);
    send_query(32'(x_bp[0] + 1), y_bp[1][31:0]);
    // non-ascending y axis
    send_write(OP_WRITE_Y, 1, 32'(y_bp[0] - 1000));
    send_query(x_bp[2][31:0], y_bp[2][31:0]);
    send_query(32'h0001_0000, 32'(y_bp[0] - 500));
    // full-range axis spans
    send_write(OP_WRITE_X, 0, 32'h8000_0000);
    send_write(OP_WRITE_X, 1, 32'h0);
    send_write(OP_WRITE_X, 2, 32'h7FFF_FFFF);
    send_query(32'hC000_0000, 32'h1234_5678);
    send_query(32'h7FFF_FFFE, 32'hFFFF_FFFF);
    drain();
    load_axis(OP_WRITE_X, 1 << 20);
    load_axis(OP_WRITE_Y, 1 << 20);
  endtask

  // point counts out of range act as the nearest limit
  task automatic test_point_limits();
    logic [PW-1:0] vals [6];
    vals = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    foreach (vals[i]) begin
      set_points(CFG_X_POINTS, vals[i]);
      set_points(CFG_Y_POINTS, vals[5 - i]);
      repeat (4) random_query();
    end
  endtask

  // random mix of queries, grid writes and axis rewrites
  task automatic test_random_phase(input int pct, input int count);
    int k;
    idle_pct = pct;
    set_points(CFG_X_POINTS, PW'($urandom_range(0, 31)));
    set_points(CFG_Y_POINTS, PW'($urandom_range(0, 31)));
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 68) random_query();
      else if (k < 84) send_write(OP_WRITE_GRID, $urandom_range(0, 255), $urandom);
      else if (k < 92) send_write(2'($urandom_range(0, 1)), $urandom_range(0, 20),
                                  $urandom_range(0, 1 << 22) - (1 << 21));
      else if (k < 96) load_axis(2'($urandom_range(0, 1)), 1 << $urandom_range(4, 28));
      else send_write(2'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom);
    end
  endtask

  // sender waits for each result before the next request
  task automatic test_pressure();
    idle_pct = 0;
    for (int n = 0; n < 12; n++) begin
      random_query();
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    x_count = 5'd2;
    y_count = 5'd2;
    idle_pct = 0;
    n_requests = 0;
    n_queries = 0;
    n_results = 0;
    n_errors = 0;
    n_cycles = 0;
    foreach (x_bp[i]) x_bp[i] = 0;
    foreach (y_bp[i]) y_bp[i] = 0;
    foreach (z_tab[i]) z_tab[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_load();
    test_directed();
    test_point_limits();
    test_random_phase(0, 45);
    test_random_phase(87, 45);
    test_random_phase(25, 45);
    test_random_phase(0, 45);
    test_pressure();
    drain();

    if (z_expected.size() != 0) begin
      $error("%0d results never arrived", z_expected.size());
      n_errors++;
    end
    $display("requests %0d, queries %0d, results %0d, cycles %0d", n_requests, n_queries,
             n_results, n_cycles);
    $display("covered table loads, clamping, zero-width and unordered cells, point limits");
    if (n_errors == 0) begin
      $display("table_interp_bilinear_2d_test: done, clean");
    end else begin
      $display("table_interp_bilinear_2d_test: done, errors");
    end
    $finish;
  end

endmodule
